// ===== rtl/bcsd_pkg.sv =====
package bcsd_pkg;

    // Default length of the dimming sub-counter cycle.
    localparam int SUB_TICK_PERIOD_DEF = 23;

    // Time keeping limits.
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    // Reset values of the clock.
    localparam logic [5:0] MIN_RESET  = 6'd30;
    localparam logic [4:0] HOUR_RESET = 5'd7;
    localparam logic [2:0] PINS_RESET = 3'b111;

    // Button pin positions.
    localparam int PIN_DOWN = 0;
    localparam int PIN_UP   = 1;
    localparam int PIN_SET  = 2;

    localparam logic [1:0] BRIGHT_FULL = 2'd3;

    typedef enum logic [1:0] {
        EV_DIM = 2'd0,
        EV_SEC = 2'd1,
        EV_BTN = 2'd2
    } evt_kind_t;

    typedef enum logic [1:0] {
        TGT_BRIGHT = 2'd0,
        TGT_HOUR   = 2'd1,
        TGT_MIN    = 2'd2
    } set_tgt_t;

    typedef struct packed {
        evt_kind_t  mode;
        logic [2:0] pins;
    } evt_t;

    typedef struct packed {
        logic [5:0] minute_leds;
        logic [4:0] hour_leds;
        logic       blink_out;
    } res_t;

endpackage

// ===== rtl/binary_clock_set_and_dimming.sv =====
// Binary LED clock with button setting and brightness dimming.
// A result is registered at its event transfer and offered on res_valid after
// any earlier results. Throughput: one event per cycle while evt_stall is low;
// one short pass updates clock and display; a two-entry buffer absorbs stalls.
// Reset: rst_n is asynchronous and active low; the clock restarts at 07:30:00
// with brightness off, set target on brightness and both result slots empty.
module binary_clock_set_and_dimming
    import bcsd_pkg::*;
#(
    parameter int SUB_TICK_PERIOD = SUB_TICK_PERIOD_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    output logic evt_stall,
    input  evt_t evt_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    // An event transfer happens whenever the output buffer has a free slot.
    // Every event yields exactly one result, so the buffer fill alone decides
    // whether the next event can be taken.
    logic take;
    logic full;
    res_t core_res;

    assign evt_stall = full;
    assign take      = evt_valid && !full;

    // Time keeping, button handling and display refresh.
    bcsd_core #(
        .SUB_TICK_PERIOD (SUB_TICK_PERIOD)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .evt   (evt_data),
        .res   (core_res)
    );

    // Output register with a skid slot, so a stalled result does not block
    // the event that arrives behind it.
    bcsd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_res),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ===== rtl/bcsd_core.sv =====
module bcsd_core
    import bcsd_pkg::*;
#(
    parameter int SUB_TICK_PERIOD = SUB_TICK_PERIOD_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic take,
    input  evt_t evt,
    output res_t res
);

    localparam int SubW = $clog2(SUB_TICK_PERIOD);
    localparam logic [SubW-1:0] SubLast = SubW'(SUB_TICK_PERIOD - 1);

    logic [SubW-1:0] sub_reg, sub_next;
    logic [5:0]      sec_reg, sec_next;
    logic [5:0]      min_reg, min_next;
    logic [4:0]      hour_reg, hour_next;
    set_tgt_t        tgt_reg, tgt_next;
    logic [1:0]      bright_reg, bright_next;
    logic            phase_reg, phase_next;
    logic [2:0]      pins_reg, pins_next;
    logic [5:0]      mdisp_reg, mdisp_next;
    logic [4:0]      hdisp_reg, hdisp_next;
    logic            blink_reg, blink_next;

    function automatic logic [5:0] reverse6(input logic [5:0] v);
        logic [5:0] r;
        for (int i = 0; i < 6; i++) begin
            r[5-i] = v[i];
        end
        return r;
    endfunction

    always_comb
    begin
        logic [2:0]      changed;
        logic            lit;
        logic            refresh;
        logic [3:0]      thr;

        sub_next    = sub_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        tgt_next    = tgt_reg;
        bright_next = bright_reg;
        phase_next  = phase_reg;
        pins_next   = pins_reg;
        blink_next  = blink_reg;
        refresh     = 1'b0;
        changed     = evt.pins ^ pins_reg;

        unique case (evt.mode)
            EV_DIM:
            begin
                sub_next = (sub_reg == SubLast) ? '0 : sub_reg + 1'b1;
                refresh  = 1'b1;
            end
            EV_SEC:
            begin
                refresh    = 1'b1;
                blink_next = ~blink_reg;
                if (sec_reg == SEC_LAST)
                begin
                    sec_next = '0;
                    if (min_reg == MIN_LAST)
                    begin
                        min_next  = '0;
                        hour_next = (hour_reg == HOUR_LAST) ? '0 : hour_reg + 1'b1;
                    end
                    else
                    begin
                        min_next = min_reg + 1'b1;
                    end
                end
                else
                begin
                    sec_next = sec_reg + 1'b1;
                end
            end
            EV_BTN:
            begin
                pins_next  = evt.pins;
                phase_next = ~phase_reg;
                // The second change of each press/release pair takes effect.
                if (phase_reg)
                begin
                    if (changed[PIN_DOWN])
                    begin
                        unique case (tgt_reg)
                            TGT_BRIGHT: bright_next = bright_next - 1'b1;
                            TGT_HOUR:   hour_next = (hour_next == '0) ? HOUR_LAST
                                                                     : hour_next - 1'b1;
                            TGT_MIN:    min_next = (min_next == '0) ? MIN_LAST
                                                                   : min_next - 1'b1;
                            default:    ;
                        endcase
                    end
                    if (changed[PIN_UP])
                    begin
                        unique case (tgt_reg)
                            TGT_BRIGHT: bright_next = bright_next + 1'b1;
                            TGT_HOUR:   hour_next = (hour_next >= HOUR_LAST) ? '0
                                                                            : hour_next + 1'b1;
                            TGT_MIN:    min_next = (min_next >= MIN_LAST) ? '0
                                                                         : min_next + 1'b1;
                            default:    ;
                        endcase
                    end
                    if (changed[PIN_SET])
                    begin
                        unique case (tgt_reg)
                            TGT_BRIGHT: tgt_next = TGT_HOUR;
                            TGT_HOUR:   tgt_next = TGT_MIN;
                            default:    tgt_next = TGT_BRIGHT;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        // Duty threshold brightness*5-4; only brightness 1 and 2 use it.
        thr = 4'({2'b00, bright_next} * 4'd5 - 4'd4);
        lit = (bright_next == BRIGHT_FULL) ||
              ((bright_next != 2'd0) && (sub_next < SubW'(thr)));

        mdisp_next = mdisp_reg;
        hdisp_next = hdisp_reg;
        if (refresh)
        begin
            if (lit)
            begin
                mdisp_next = reverse6(min_next);
                hdisp_next = hour_next;
            end
            else
            begin
                if (tgt_next != TGT_HOUR)
                begin
                    mdisp_next = '0;
                end
                if (tgt_next != TGT_MIN)
                begin
                    hdisp_next = '0;
                end
            end
        end

        res.minute_leds = mdisp_next;
        res.hour_leds   = hdisp_next;
        res.blink_out   = blink_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg    <= '0;
            sec_reg    <= '0;
            min_reg    <= MIN_RESET;
            hour_reg   <= HOUR_RESET;
            tgt_reg    <= TGT_BRIGHT;
            bright_reg <= '0;
            phase_reg  <= 1'b0;
            pins_reg   <= PINS_RESET;
            mdisp_reg  <= '0;
            hdisp_reg  <= '0;
            blink_reg  <= 1'b0;
        end
        else if (take)
        begin
            sub_reg    <= sub_next;
            sec_reg    <= sec_next;
            min_reg    <= min_next;
            hour_reg   <= hour_next;
            tgt_reg    <= tgt_next;
            bright_reg <= bright_next;
            phase_reg  <= phase_next;
            pins_reg   <= pins_next;
            mdisp_reg  <= mdisp_next;
            hdisp_reg  <= hdisp_next;
            blink_reg  <= blink_next;
        end
    end

endmodule

// ===== rtl/bcsd_skid.sv =====
module bcsd_skid
    import bcsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic pop;

    assign pop       = out_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== verif/bcsd_checker.sv =====
module bcsd_checker
    import bcsd_pkg::*;
#(
    parameter int SUB_TICK_PERIOD = SUB_TICK_PERIOD_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    input  logic evt_stall,
    input  evt_t evt_data,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res_data,
    output int   evt_seen,
    output int   res_seen,
    output int   err_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Local copy of the clock state.
    int         sub_count;
    logic [5:0] secs;
    logic [5:0] mins;
    logic [4:0] hrs;
    set_tgt_t   set_tgt;
    logic [1:0] bright;
    logic       phase;
    logic [2:0] prev_pins;
    logic [5:0] min_disp;
    logic [4:0] hour_disp;
    logic       blink_lvl;

    res_t display_q[$];

    task automatic clear_clock();
        sub_count = 0;
        secs      = '0;
        mins      = MIN_RESET;
        hrs       = HOUR_RESET;
        set_tgt   = TGT_BRIGHT;
        bright    = '0;
        phase     = 1'b0;
        prev_pins = PINS_RESET;
        min_disp  = '0;
        hour_disp = '0;
        blink_lvl = 1'b0;
    endtask

    // Dimming: lit for the first brightness*5-4 sub steps, always at full, never at zero.
    task automatic refresh_leds();
        logic lit;
        lit = (bright != 2'd0) &&
              ((bright == BRIGHT_FULL) || (sub_count < int'(bright) * 5 - 4));
        if (lit) begin
            min_disp  = {mins[0], mins[1], mins[2], mins[3], mins[4], mins[5]};
            hour_disp = hrs;
        end
        else begin
            if (set_tgt != TGT_HOUR) begin
                min_disp = '0;
            end
            if (set_tgt != TGT_MIN) begin
                hour_disp = '0;
            end
        end
    endtask

    task automatic count_second();
        if (secs == SEC_LAST) begin
            secs = '0;
            if (mins == MIN_LAST) begin
                mins = '0;
                hrs  = (hrs == HOUR_LAST) ? 5'd0 : hrs + 5'd1;
            end
            else begin
                mins = mins + 6'd1;
            end
        end
        else begin
            secs = secs + 6'd1;
        end
        blink_lvl = ~blink_lvl;
    endtask

    // Press and release both toggle the phase; changes act on the second one.
    task automatic apply_buttons(input logic [2:0] pin_levels);
        logic [2:0] changed;
        set_tgt_t   tgt;
        changed   = pin_levels ^ prev_pins;
        tgt       = set_tgt;
        prev_pins = pin_levels;
        phase     = ~phase;
        if (phase == 1'b0) begin
            if (changed[PIN_DOWN]) begin
                case (tgt)
                    TGT_BRIGHT: bright = bright - 2'd1;
                    TGT_HOUR:   hrs = (hrs == 5'd0) ? HOUR_LAST : hrs - 5'd1;
                    TGT_MIN:    mins = (mins == 6'd0) ? MIN_LAST : mins - 6'd1;
                    default:    ;
                endcase
            end
            if (changed[PIN_UP]) begin
                case (tgt)
                    TGT_BRIGHT: bright = bright + 2'd1;
                    TGT_HOUR:   hrs = (hrs >= HOUR_LAST) ? 5'd0 : hrs + 5'd1;
                    TGT_MIN:    mins = (mins >= MIN_LAST) ? 6'd0 : mins + 6'd1;
                    default:    ;
                endcase
            end
            if (changed[PIN_SET]) begin
                set_tgt = set_tgt_t'((int'(set_tgt) + 1) % 3);
            end
        end
    endtask

    task automatic compute_display(input evt_t ev, output res_t shown);
        case (ev.mode)
            EV_DIM:
            begin
                sub_count = (sub_count + 1) % SUB_TICK_PERIOD;
                refresh_leds();
            end
            EV_SEC:
            begin
                count_second();
                refresh_leds();
            end
            EV_BTN:  apply_buttons(ev.pins);
            default: ;
        endcase
        shown.minute_leds = min_disp;
        shown.hour_leds   = hour_disp;
        shown.blink_out   = blink_lvl;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        res_t want;
        res_t next_res;
        int   bad;
        if (!rst_n) begin
            clear_clock();
            display_q.delete();
            evt_seen  <= 0;
            res_seen  <= 0;
            err_count <= 0;
        end
        else begin
            bad = 0;
            // Results are checked before this edge's event is predicted, since the
            // block never returns a result in the cycle its event is taken.
            if (res_valid && !res_stall) begin
                res_seen <= res_seen + 1;
                if (display_q.size() == 0) begin
                    $error("result transfer with nothing expected: %p", res_data);
                    bad++;
                end
                else begin
                    want = display_q.pop_front();
                    if (res_data.minute_leds !== want.minute_leds) begin
                        $error("minute_leds: expected %0d, actual %0d",
                               want.minute_leds, res_data.minute_leds);
                        bad++;
                    end
                    if (res_data.hour_leds !== want.hour_leds) begin
                        $error("hour_leds: expected %0d, actual %0d",
                               want.hour_leds, res_data.hour_leds);
                        bad++;
                    end
                    if (res_data.blink_out !== want.blink_out) begin
                        $error("blink_out: expected %0d, actual %0d",
                               want.blink_out, res_data.blink_out);
                        bad++;
                    end
                end
            end
            if (evt_valid && !evt_stall) begin
                compute_display(evt_data, next_res);
                display_q.push_back(next_res);
                evt_seen <= evt_seen + 1;
            end
            if (bad != 0) begin
                err_count <= err_count + bad;
            end
        end
    end

endmodule

// ===== verif/tb_binary_clock_set_and_dimming.sv =====
module tb_binary_clock_set_and_dimming;
    timeunit 1ns;
    timeprecision 1ps;

    import bcsd_pkg::*;

    // The event kind that the block must ignore.
    localparam logic [1:0] EV_UNUSED = 2'd3;

    // Random events after the directed opening.
    localparam int RANDOM_EVENTS = 1400;

    logic clk;
    logic rst_n;
    logic evt_valid;
    logic evt_stall;
    evt_t evt_data;
    logic res_valid;
    logic res_stall;
    res_t res_data;

    int evt_seen;
    int res_seen;
    int err_count;

    // Bookkeeping on the sending side, used for pacing and the summary.
    int         sent_total;
    int         sent_dim;
    int         sent_sec;
    int         sent_btn;
    int         sent_unused;
    logic [2:0] cur_pins;
    bit         tx_calm;

    binary_clock_set_and_dimming #(
        .SUB_TICK_PERIOD(SUB_TICK_PERIOD_DEF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt_valid(evt_valid),
        .evt_stall(evt_stall),
        .evt_data (evt_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data)
    );

    // The checker sits beside the block, predicts every result from the event
    // transfers it sees and compares the result transfers against them.
    bcsd_checker #(
        .SUB_TICK_PERIOD(SUB_TICK_PERIOD_DEF)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt_valid(evt_valid),
        .evt_stall(evt_stall),
        .evt_data (evt_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data),
        .evt_seen (evt_seen),
        .res_seen (res_seen),
        .err_count(err_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back or short gaps, with an occasional long one so that a
    // pause can land on any state of the output buffer.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    // Presents one event and holds it until the transfer happens. A gap of zero
    // keeps valid high, so valid only gets one assignment per time step.
    task automatic send_event(input logic [1:0] kind, input logic [2:0] pin_levels);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid     <= 1'b1;
        evt_data.mode <= evt_kind_t'(kind);
        evt_data.pins <= pin_levels;
        do @(posedge clk); while (evt_stall);
        sent_total++;
        case (kind)
            EV_DIM:  sent_dim++;
            EV_SEC:  sent_sec++;
            EV_BTN:  sent_btn++;
            default: sent_unused++;
        endcase
    endtask

    // A well-formed button action is a press followed by the matching release;
    // the release is the change that the clock acts on when the phase is aligned.
    task automatic press_buttons(input logic [2:0] mask);
        send_event(EV_BTN, cur_pins ^ mask);
        send_event(EV_BTN, cur_pins);
    endtask

    // Lowers valid and holds off until every expected result has come back.
    task automatic wait_drained();
        evt_valid <= 1'b0;
        do @(posedge clk); while (evt_seen != res_seen);
    endtask

    // The result side stalls in random bursts, with long stall-free stretches.
    initial begin : result_side
        int open_len;
        int hold_len;
        int r;
        res_stall <= 1'b0;
        forever begin
            open_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
            repeat (open_len) begin
                @(posedge clk);
                res_stall <= 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                hold_len = 0;
            end
            else if (r < 85) begin
                hold_len = $urandom_range(1, 3);
            end
            else begin
                hold_len = $urandom_range(10, 40);
            end
            repeat (hold_len) begin
                @(posedge clk);
                res_stall <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int         pick;
        int         burst;
        logic [2:0] mask;
        bit         paused;

        evt_valid   <= 1'b0;
        evt_data    <= '0;
        rst_n       <= 1'b0;
        sent_total  = 0;
        sent_dim    = 0;
        sent_sec    = 0;
        sent_btn    = 0;
        sent_unused = 0;
        cur_pins    = PINS_RESET;
        tx_calm     = 1'b0;
        paused      = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. Brightness starts at zero, so the first ticks show
        // a dark display.
        send_event(EV_DIM, 3'b000);
        send_event(EV_SEC, 3'b111);
        // Down from brightness zero wraps around to full.
        press_buttons(3'b001 << PIN_DOWN);
        send_event(EV_DIM, 3'b000);
        // Up from full wraps to off, then one more step gives the dimmest level.
        press_buttons(3'b001 << PIN_UP);
        press_buttons(3'b001 << PIN_UP);
        repeat (3) send_event(EV_DIM, 3'b000);
        // Move the set target to hours; the unlit minute field is cleared and
        // the hour field holds while hours are being set.
        press_buttons(3'b001 << PIN_SET);
        // All three pins at once: down and up cancel, the target moves on.
        press_buttons(3'b111);
        press_buttons(3'b001 << PIN_DOWN);
        send_event(EV_SEC, 3'b000);
        // The unused event kind changes nothing.
        send_event(EV_UNUSED, 3'b000);
        send_event(EV_UNUSED, 3'b111);
        press_buttons(3'b001 << PIN_SET);
        send_event(EV_DIM, 3'b000);

        // Random part: mostly well-formed actions and tick bursts with random
        // content, plus single unmatched pin changes that shift the press phase.
        while (sent_total < 25 + RANDOM_EVENTS) begin
            if ($urandom_range(0, 9) == 0) begin
                tx_calm = ~tx_calm;
            end
            if (!paused && sent_total > 25 + RANDOM_EVENTS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                burst = $urandom_range(1, 30);
                repeat (burst) send_event(EV_DIM, 3'($urandom_range(0, 7)));
            end
            else if (pick < 65) begin
                // Now and then a burst of 55 to 70 seconds, close to a minute, to drive the carries.
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70)
                                                    : $urandom_range(1, 8);
                repeat (burst) send_event(EV_SEC, 3'($urandom_range(0, 7)));
            end
            else if (pick < 93) begin
                if ($urandom_range(0, 99) < 70) begin
                    mask = 3'b001 << $urandom_range(0, 2);
                end
                else begin
                    mask = 3'($urandom_range(1, 7));
                end
                press_buttons(mask);
            end
            else if (pick < 97) begin
                cur_pins = 3'($urandom_range(0, 7));
                send_event(EV_BTN, cur_pins);
            end
            else begin
                send_event(EV_UNUSED, 3'($urandom_range(0, 7)));
            end
        end

        // Let the last results drain, then watch the idle block for a while in case
        // it offers anything unexpected.
        wait_drained();
        repeat (10) @(posedge clk);

        if (evt_seen != res_seen) begin
            $error("%0d events sent but %0d results returned", evt_seen, res_seen);
        end
        $display("Covered %0d events: %0d dimming ticks, %0d second ticks, %0d pin changes,",
                 sent_total, sent_dim, sent_sec, sent_btn);
        $display("%0d of the unused kind; %0d results compared under random stalls.",
                 sent_unused, res_seen);
        if (err_count == 0 && evt_seen == res_seen) begin
            $display("tb_binary_clock_set_and_dimming: done, clean");
        end
        else begin
            $display("tb_binary_clock_set_and_dimming: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest expected run.
    initial begin : watchdog
        #5ms;
        $display("tb_binary_clock_set_and_dimming: done, errors");
        $finish;
    end

endmodule
